### hdl/asn1_tlv_header_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// ASN.1 TLV header decoder assertion macros
// Concurrent check wrappers used by the decoder core RTL; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASN1_TLV_HEADER_DECODER_CORE_ASSERT_SVH
`define ASN1_TLV_HEADER_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ATHD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("athd check failed");

// next-cycle implication
`define ATHD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("athd check failed");

`else

`define ATHD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ATHD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/athd_pkg.sv
// ----------------------------------------------------------------------------
// ASN.1 TLV header decoder package
// Transfer types, status and parse phase codes, identifier masks.
// ----------------------------------------------------------------------------
package athd_pkg;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    // parse phases
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_LEN_FIRST = 2'd1;
    localparam logic [1:0] PH_LEN_MORE  = 2'd2;

    // identifier / length octet fields
    localparam logic [7:0] ID_CLASS_MASK = 8'b1100_0000;
    localparam logic [7:0] ID_CONS_MASK  = 8'b0010_0000;
    localparam logic [7:0] ID_TAG_MASK   = 8'b0001_1111;
    localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
    localparam logic [7:0] LEN_NUM_MASK  = 8'h7f;
    localparam logic [4:0] TAG_HIGH_FORM = 5'h1f;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  ident_class;
        logic        constructed;
        logic [4:0]  ident_tag;
        logic [63:0] content_len;
        logic [3:0]  header_bytes;
        logic [63:0] total_bytes;
    } out_item_t;

endpackage

### hdl/athd_stream_if.sv
// ----------------------------------------------------------------------------
// ASN.1 TLV header decoder stream interface
// Valid/ready channel; one transfer when both are high at a rising edge.
// ----------------------------------------------------------------------------
interface athd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### hdl/athd_parse.sv
// ----------------------------------------------------------------------------
// ASN.1 TLV header decoder parse step
// Header parse state and the combinational decode of one byte.
// ----------------------------------------------------------------------------
module athd_parse
    import athd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output logic      emit,
    output out_item_t result
);

    localparam logic [6:0] MAX_N = 7'(MAX_LENGTH_BYTES);

    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  count_reg, count_next;
    logic [1:0]  class_reg, class_next;
    logic        cons_reg, cons_next;
    logic [4:0]  num_reg, num_next;
    logic [1:0]  st;
    logic [63:0] vlen;
    logic [6:0]  len_n;
    logic        ok;

    assign len_n = 7'(item.data_byte & LEN_NUM_MASK);

    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        class_next = class_reg;
        cons_next  = cons_reg;
        num_next   = num_reg;
        emit       = 1'b0;
        st         = ST_OK;
        vlen       = '0;
        if (item.first_byte)
        begin
            class_next = item.data_byte[7:6];
            cons_next  = |(item.data_byte & ID_CONS_MASK);
            num_next   = 5'(item.data_byte & ID_TAG_MASK);
            count_next = 4'd1;
            left_next  = '0;
            acc_next   = '0;
            if (num_next == TAG_HIGH_FORM)
            begin
                emit = 1'b1;
                st   = ST_UNSUPPORTED;
            end
            else if (item.last_byte)
            begin
                emit = 1'b1;
                st   = ST_INVALID;
            end
            else
            begin
                phase_next = PH_LEN_FIRST;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LEN_FIRST:
                begin
                    count_next = 4'd2;
                    if (item.data_byte == LEN_LONG_FLAG)
                    begin
                        emit = 1'b1;
                        st   = ST_UNSUPPORTED;
                    end
                    else if ((item.data_byte & LEN_LONG_FLAG) == 8'h00)
                    begin
                        emit = 1'b1;
                        vlen = {56'd0, item.data_byte};
                    end
                    else if (len_n > MAX_N)
                    begin
                        emit = 1'b1;
                        st   = ST_UNSUPPORTED;
                    end
                    else if (item.last_byte)
                    begin
                        emit = 1'b1;
                        st   = ST_INVALID;
                    end
                    else
                    begin
                        left_next  = len_n[3:0];
                        acc_next   = '0;
                        phase_next = PH_LEN_MORE;
                    end
                end
                PH_LEN_MORE:
                begin
                    acc_next   = {acc_reg[55:0], item.data_byte};
                    count_next = count_reg + 4'd1;
                    if (left_reg != 4'd0)
                    begin
                        left_next = left_reg - 4'd1;
                    end
                    if (left_next == 4'd0)
                    begin
                        emit = 1'b1;
                        vlen = acc_next;
                    end
                    else if (item.last_byte)
                    begin
                        emit = 1'b1;
                        st   = ST_INVALID;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        if (emit)
        begin
            phase_next = PH_IDLE;
        end
    end

    assign ok = (st == ST_OK);

    always_comb
    begin
        result.status       = st;
        result.ident_class  = class_next;
        result.constructed  = cons_next;
        result.ident_tag    = ok ? num_next : 5'd0;
        result.content_len  = ok ? vlen : 64'd0;
        result.header_bytes = count_next;
        result.total_bytes  = ok ? ({60'd0, count_next} + vlen) : 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            left_reg  <= '0;
            acc_reg   <= '0;
            count_reg <= '0;
            class_reg <= '0;
            cons_reg  <= 1'b0;
            num_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            class_reg <= class_next;
            cons_reg  <= cons_next;
            num_reg   <= num_next;
        end
    end

endmodule

### hdl/asn1_tlv_header_decoder_core.sv
// ----------------------------------------------------------------------------
// ASN.1 TLV header decoder core
// Byte-stream BER/DER identifier and length decoder, one result per header.
// ----------------------------------------------------------------------------
// Feed the encoded buffer one byte per transfer on byte_in, with first_byte
// set on the identifier octet and last_byte set on the final byte of the
// buffer. Each header yields one transfer on hdr_out carrying the status
// (ok, invalid/truncated, unsupported), class, constructed flag, tag number,
// decoded content length, header size and header-plus-content total. The
// core sustains one byte per clock unless the result register stalls: each
// byte passes an input register, a combinational parse step (shift-in of a
// length octet, a few compares, one 64-bit add) and a result register,
// which takes the result of the byte that completes or aborts the header.
// An input byte stalls only when its result cannot enter a full, stalled
// result register. High-form tag numbers, indefinite lengths and long forms
// wider than MAX_LENGTH_BYTES octets are reported as unsupported. A
// first_byte during an unfinished header drops that header silently; bytes
// outside a header are discarded with no result.
// ----------------------------------------------------------------------------
`include "asn1_tlv_header_decoder_core_assert.svh"

module asn1_tlv_header_decoder_core
    import athd_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    athd_stream_if.sink   byte_in,
    athd_stream_if.source hdr_out
);

    // input register
    logic      in_valid_reg;
    in_item_t  in_item_reg;

    // result register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic      emit;
    out_item_t result;
    logic      out_free;
    logic      advance;

    // byte in the input register moves on unless its result is blocked
    assign out_free      = !out_valid_reg || hdr_out.ready;
    assign advance       = in_valid_reg && (!emit || out_free);
    assign byte_in.ready = !in_valid_reg || advance;

    assign hdr_out.valid   = out_valid_reg;
    assign hdr_out.payload = out_item_reg;

    athd_parse #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .emit   (emit),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            in_item_reg <= byte_in.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (hdr_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_item_reg <= result;
        end
    end

    // error results carry no tag number, content length or total byte count
    `ATHD_ASSERT_IMP(a_err_zero, clk, rst_n,
        out_valid_reg && (out_item_reg.status != ST_OK),
        (out_item_reg.ident_tag == 5'd0) && (out_item_reg.content_len == 64'd0)
            && (out_item_reg.total_bytes == 64'd0))

    // an ok result always spans identifier plus at least one length octet
    `ATHD_ASSERT_IMP(a_ok_size, clk, rst_n,
        out_valid_reg && (out_item_reg.status == ST_OK),
        (out_item_reg.header_bytes >= 4'd2) && (out_item_reg.header_bytes <= 4'd10)
            && (out_item_reg.total_bytes
                == ({60'd0, out_item_reg.header_bytes} + out_item_reg.content_len)))

    // a blocked byte stays in the input register
    `ATHD_ASSERT_NXT(a_in_hold, clk, rst_n,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg))

    // a result is never dropped: a new one only enters a free result register
    `ATHD_ASSERT_IMP(a_no_overwrite, clk, rst_n,
        advance && emit,
        out_free)

endmodule
